[hw/rtl/skl_pkg.sv]
// Shared types, constants and the tanh table builder for the soft-knee limiter.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package skl_pkg;

  localparam int SampleBits = 24;
  localparam int CeilBits   = 21;
  localparam int KneeBits   = 16;
  localparam int BlkBits    = 13;
  localparam int MaxBlock   = 4096;
  localparam int TanhSize   = 256;
  localparam int TanhIdxW   = 8;   // bits of table index below the end point
  localparam int TanhW      = 30;  // Q0.30 table entries
  localparam int QuotW      = 27;  // quotient bits of the shared divider
  localparam int RemW       = 39;
  localparam int DivW       = 38;

  localparam logic [CeilBits-1:0] FullScale = 21'd1048576;
  localparam logic [KneeBits-1:0] KneeReset = 16'd52429;
  localparam logic [BlkBits-1:0]  BlkReset  = 13'd512;

  // register index codes
  localparam logic [1:0] RegCeiling = 2'd0;
  localparam logic [1:0] RegKnee    = 2'd1;
  localparam logic [1:0] RegBlock   = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CSEL, OP_RDIV, OP_RFIN, OP_KNEE, OP_CMP, OP_ZERO,
    OP_PASS, OP_SAT, OP_EDIV, OP_T0, OP_T1, OP_IMUL, OP_IADD, OP_S1, OP_S2,
    OP_S3, OP_S4
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic ramp_div;   // ramp in progress and not on its last sample
    logic not_finite;
    logic knee_pass;
    logic saturate;
    logic div_done;
  } dp_stat_t;

  typedef logic [TanhW-1:0] tanh_lut_t [0:TanhSize];

  // Shift-subtract long division for non-negative operands, elaboration only.
  function automatic longint udiv(input longint num, input longint den);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((num >>> b) & 64'sd1);
      if (r >= den) begin
        r = r - den;
        q = q | (64'sd1 <<< b);
      end
    end
    return q;
  endfunction

  // Built at elaboration only: exp series, four squarings, then (1-z)/(1+z).
  function automatic tanh_lut_t build_tanh_lut();
    tanh_lut_t lut;
    longint one;
    longint f;
    longint term;
    longint sum;
    longint z;
    longint q;
    one = 64'sd1 << 30;
    for (int i = 0; i <= TanhSize; i++) begin
      f    = (longint'(i) << 30) >>> TanhIdxW;
      term = one;
      sum  = one;
      for (int k = 1; k <= 20; k++) begin
        term = udiv((term * f) >>> 30, longint'(k));
        if ((k & 1) == 1) sum = sum - term;
        else sum = sum + term;
      end
      if (sum < 0) sum = 0;
      if (sum > one) sum = one;
      z = sum;
      for (int k = 0; k < 4; k++) z = (z * z) >>> 30;
      q = udiv((one - z) << 30, one + z);
      if (q > one - 1) q = one - 1;
      lut[i] = q[TanhW-1:0];
    end
    return lut;
  endfunction

endpackage

[hw/rtl/skl_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the ramp and the
// excess computation. Uses skl_pkg widths.
`timescale 1ns / 1ps

module skl_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [skl_pkg::RemW-1:0]  rem_init,   // dividend >> QuotW, below divisor
  input  logic [skl_pkg::QuotW-1:0] low_init,   // low dividend bits
  input  logic [skl_pkg::DivW-1:0]  divisor,
  output logic [skl_pkg::QuotW-1:0] quotient,
  output logic                      done
);

  logic [skl_pkg::RemW-1:0]  rem_r;
  logic [skl_pkg::QuotW-1:0] sh_r;
  logic [skl_pkg::DivW-1:0]  dvs_r;
  logic [4:0]                cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [skl_pkg::RemW-1:0]  trial;
  logic                      fits;

  assign trial = {rem_r[skl_pkg::RemW-2:0], sh_r[skl_pkg::QuotW-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 5'(skl_pkg::QuotW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      sh_r  <= low_init;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? trial - {1'b0, dvs_r} : trial;
      sh_r  <= {sh_r[skl_pkg::QuotW-2:0], fits};
    end
  end

  assign quotient = sh_r;
  assign done     = done_r;

endmodule

[hw/rtl/skl_ctrl.sv]
// Sequencer for the limiter: walks one sample through ramp, knee test,
// division, table interpolation and scaling. Uses skl_pkg command types.
`timescale 1ns / 1ps

module skl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_free,
  input  skl_pkg::dp_stat_t stat,
  output skl_pkg::dp_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CSEL  = 5'd1;
  localparam logic [4:0] S_RDIV  = 5'd2;
  localparam logic [4:0] S_RWAIT = 5'd3;
  localparam logic [4:0] S_RFIN  = 5'd4;
  localparam logic [4:0] S_KNEE  = 5'd5;
  localparam logic [4:0] S_CMP   = 5'd6;
  localparam logic [4:0] S_BR    = 5'd7;
  localparam logic [4:0] S_EWAIT = 5'd8;
  localparam logic [4:0] S_T0    = 5'd9;
  localparam logic [4:0] S_T1    = 5'd10;
  localparam logic [4:0] S_IMUL  = 5'd11;
  localparam logic [4:0] S_IADD  = 5'd12;
  localparam logic [4:0] S_S1    = 5'd13;
  localparam logic [4:0] S_S2    = 5'd14;
  localparam logic [4:0] S_S3    = 5'd15;
  localparam logic [4:0] S_S4    = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0] state_r;
  logic [4:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = skl_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = skl_pkg::OP_LOAD;
          state_nxt = S_CSEL;
        end
      end
      S_CSEL: begin
        cmd.op    = skl_pkg::OP_CSEL;
        state_nxt = stat.ramp_div ? S_RDIV : S_KNEE;
      end
      S_RDIV: begin
        cmd.op    = skl_pkg::OP_RDIV;
        state_nxt = S_RWAIT;
      end
      S_RWAIT: if (stat.div_done) state_nxt = S_RFIN;
      S_RFIN: begin
        cmd.op    = skl_pkg::OP_RFIN;
        state_nxt = S_KNEE;
      end
      S_KNEE: begin
        cmd.op    = skl_pkg::OP_KNEE;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.op    = skl_pkg::OP_CMP;
        state_nxt = S_BR;
      end
      S_BR: begin
        if (stat.not_finite) begin
          cmd.op    = skl_pkg::OP_ZERO;
          state_nxt = S_DONE;
        end else if (stat.knee_pass) begin
          cmd.op    = skl_pkg::OP_PASS;
          state_nxt = S_DONE;
        end else if (stat.saturate) begin
          cmd.op    = skl_pkg::OP_SAT;
          state_nxt = S_S1;
        end else begin
          cmd.op    = skl_pkg::OP_EDIV;
          state_nxt = S_EWAIT;
        end
      end
      S_EWAIT: if (stat.div_done) state_nxt = S_T0;
      S_T0: begin
        cmd.op    = skl_pkg::OP_T0;
        state_nxt = S_T1;
      end
      S_T1: begin
        cmd.op    = skl_pkg::OP_T1;
        state_nxt = S_IMUL;
      end
      S_IMUL: begin
        cmd.op    = skl_pkg::OP_IMUL;
        state_nxt = S_IADD;
      end
      S_IADD: begin
        cmd.op    = skl_pkg::OP_IADD;
        state_nxt = S_S1;
      end
      S_S1: begin
        cmd.op    = skl_pkg::OP_S1;
        state_nxt = S_S2;
      end
      S_S2: begin
        cmd.op    = skl_pkg::OP_S2;
        state_nxt = S_S3;
      end
      S_S3: begin
        cmd.op    = skl_pkg::OP_S3;
        state_nxt = S_S4;
      end
      S_S4: begin
        cmd.op    = skl_pkg::OP_S4;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[hw/rtl/skl_dp.sv]
// Limiter datapath: ceiling ramp state, knee test, excess, tanh table
// interpolation and output scaling. Depends on skl_pkg and skl_div.
`timescale 1ns / 1ps

module skl_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  skl_pkg::dp_cmd_t               cmd,
  output skl_pkg::dp_stat_t              stat,
  input  logic signed [skl_pkg::SampleBits-1:0] sample_in,
  input  logic                           not_finite,
  input  logic                           ceil_we,
  input  logic [skl_pkg::CeilBits-1:0]   ceil_wdata,
  input  logic [skl_pkg::CeilBits-1:0]   ceiling,
  input  logic [skl_pkg::KneeBits-1:0]   knee_fraction,
  input  logic [skl_pkg::BlkBits-1:0]    block_length,
  output logic [skl_pkg::SampleBits-1:0] result
);

  localparam skl_pkg::tanh_lut_t TanhLut = skl_pkg::build_tanh_lut();

  // ramp state
  logic [skl_pkg::CeilBits-1:0] settled_r;
  logic [skl_pkg::CeilBits-1:0] origin_r;
  logic [skl_pkg::BlkBits-1:0]  pos_r;
  logic                         active_r;

  logic signed [skl_pkg::SampleBits-1:0] x_r;
  logic                                  nf_r;
  logic [skl_pkg::CeilBits-1:0]          c_r;
  logic signed [34:0]                    rnum_r;
  logic [23:0]                           mag_r;
  logic [36:0]                           knee_r;
  logic [37:0]                           den_r;
  logic [39:0]                           nume_r;
  logic                                  pass_r;
  logic                                  sat_r;
  logic [skl_pkg::TanhW-1:0]             t0_r;
  logic [skl_pkg::TanhW-1:0]             dlt_r;
  logic [56:0]                           ip_r;
  logic [skl_pkg::TanhW-1:0]             t_r;
  logic [46:0]                           sp_r;
  logic [29:0]                           s_r;
  logic [50:0]                           o_r;
  logic [skl_pkg::SampleBits-1:0]        res_r;

  logic [skl_pkg::BlkBits-1:0]  blk_eff;
  logic [13:0]                  pos_inc;
  logic                         ramp_last;
  logic signed [21:0]           span;
  logic [33:0]                  rmag;
  logic [35:0]                  rdvd;
  logic [16:0]                  kf_inv;
  logic [39:0]                  mag_sh;
  logic [8:0]                   idx;
  logic [26:0]                  frac;
  logic [30:0]                  t_sum;
  logic [47:0]                  s_sum;
  logic [20:0]                  o_mag;
  logic [20:0]                  q_mag;
  logic signed [22:0]           c_new;
  logic                         div_start;
  logic [skl_pkg::RemW-1:0]     div_rem;
  logic [skl_pkg::QuotW-1:0]    div_low;
  logic [skl_pkg::DivW-1:0]     div_dvs;
  logic [skl_pkg::QuotW-1:0]    quot;
  logic                         div_done;

  always_comb begin
    if (block_length == '0) blk_eff = skl_pkg::BlkBits'(1);
    else if (block_length > skl_pkg::BlkBits'(skl_pkg::MaxBlock))
      blk_eff = skl_pkg::BlkBits'(skl_pkg::MaxBlock);
    else blk_eff = block_length;
  end

  assign pos_inc   = {1'b0, pos_r} + 14'd1;
  assign ramp_last = pos_inc >= {1'b0, blk_eff};
  assign span      = $signed({1'b0, ceiling}) - $signed({1'b0, origin_r});
  assign rmag      = rnum_r[34] ? 34'(-rnum_r) : rnum_r[33:0];
  // round half away from zero: (2|num| + N) / 2N
  assign rdvd      = {1'b0, rmag, 1'b0} + 36'(blk_eff);
  assign kf_inv    = 17'd65536 - {1'b0, knee_fraction};
  assign mag_sh    = {mag_r, 16'b0};
  assign idx       = {1'b0, quot[26:19]};
  assign frac      = {quot[18:0], 8'b0};
  assign t_sum     = {1'b0, t0_r} + 31'(ip_r[56:27]);
  assign s_sum     = {2'b0, knee_fraction, 30'b0} + {1'b0, sp_r};
  assign o_mag     = o_r[50:30];
  assign q_mag     = quot[20:0];
  assign c_new     = rnum_r[34] ? $signed({2'b0, origin_r}) - $signed({2'b0, q_mag})
                                : $signed({2'b0, origin_r}) + $signed({2'b0, q_mag});

  always_comb begin
    div_start = 1'b0;
    div_rem   = '0;
    div_low   = '0;
    div_dvs   = '0;
    case (cmd.op)
      skl_pkg::OP_RDIV: begin
        div_start = 1'b1;
        div_rem   = skl_pkg::RemW'(rdvd[35:27]);
        div_low   = rdvd[26:0];
        div_dvs   = skl_pkg::DivW'({blk_eff, 1'b0});
      end
      skl_pkg::OP_EDIV: begin
        div_start = 1'b1;
        div_rem   = skl_pkg::RemW'(nume_r[39:3]);
        div_low   = {nume_r[2:0], 24'b0};
        div_dvs   = den_r;
      end
      default: div_start = 1'b0;
    endcase
  end

  skl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem),
    .low_init (div_low),
    .divisor  (div_dvs),
    .quotient (quot),
    .done     (div_done)
  );

  // ramp control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settled_r <= skl_pkg::FullScale;
      origin_r  <= skl_pkg::FullScale;
      pos_r     <= '0;
      active_r  <= 1'b0;
    end else if (ceil_we) begin
      origin_r <= settled_r;
      pos_r    <= '0;
      active_r <= (settled_r != ceil_wdata);
    end else begin
      case (cmd.op)
        skl_pkg::OP_CSEL: begin
          if (active_r && ramp_last) begin
            active_r <= 1'b0;
            pos_r    <= '0;
          end
        end
        skl_pkg::OP_RFIN: pos_r <= pos_inc[skl_pkg::BlkBits-1:0];
        skl_pkg::OP_KNEE: settled_r <= c_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      skl_pkg::OP_LOAD: begin
        x_r  <= sample_in;
        nf_r <= not_finite;
      end
      skl_pkg::OP_CSEL: begin
        if (!active_r) c_r <= settled_r;
        else if (ramp_last) c_r <= ceiling;
        else rnum_r <= 35'(span * $signed({1'b0, pos_inc}));
      end
      skl_pkg::OP_RFIN: c_r <= c_new[skl_pkg::CeilBits-1:0];
      skl_pkg::OP_KNEE: begin
        knee_r <= 37'(knee_fraction * c_r);
        den_r  <= 38'(c_r * kf_inv);
        mag_r  <= x_r[skl_pkg::SampleBits-1] ? 24'(-x_r) : 24'(x_r);
      end
      skl_pkg::OP_CMP: begin
        pass_r <= mag_sh <= {3'b0, knee_r};
        nume_r <= mag_sh - {3'b0, knee_r};
        sat_r  <= (mag_sh - {3'b0, knee_r}) >= {den_r, 3'b0};
      end
      skl_pkg::OP_ZERO: res_r <= '0;
      skl_pkg::OP_PASS: res_r <= x_r;
      skl_pkg::OP_SAT:  t_r <= TanhLut[skl_pkg::TanhSize];
      skl_pkg::OP_T0:   t0_r <= TanhLut[idx];
      skl_pkg::OP_T1:   dlt_r <= TanhLut[idx + 9'd1] - t0_r;
      skl_pkg::OP_IMUL: ip_r <= 57'(dlt_r * frac);
      skl_pkg::OP_IADD: begin
        if (t_sum > 31'h3FFF_FFFF) t_r <= 30'h3FFF_FFFF;
        else t_r <= t_sum[29:0];
      end
      skl_pkg::OP_S1: sp_r <= 47'(kf_inv * t_r);
      skl_pkg::OP_S2: s_r <= s_sum[45:16];
      skl_pkg::OP_S3: o_r <= 51'(c_r * s_r);
      skl_pkg::OP_S4: begin
        if (x_r[skl_pkg::SampleBits-1]) res_r <= 24'(-{3'b0, o_mag});
        else res_r <= {3'b0, o_mag};
      end
      default: ;
    endcase
  end

  assign stat.ramp_div   = active_r && !ramp_last;
  assign stat.not_finite = nf_r;
  assign stat.knee_pass  = pass_r;
  assign stat.saturate   = sat_r;
  assign stat.div_done   = div_done;
  assign result          = res_r;

endmodule

[hw/rtl/soft_knee_tanh_limiter.sv]
// Soft-knee tanh limiter top: APB register file, output register, sequencer
// and datapath. Depends on skl_pkg, skl_ctrl, skl_dp (which holds skl_div).
// A sample below the knee passes unchanged, a saturated one skips the division,
// the rest go through the excess division and the tanh table, and a ramp step
// first needs the shared 27-step divider. One sample is in work at a time;
// a new request can be taken while the last result waits in the output register.
// Reset (synchronous, rst_n low): registers to reset values, no ramp, idle.
`timescale 1ns / 1ps

module soft_knee_tanh_limiter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [23:0] sample_in
  input  logic [0:0]  in_tuser,    // [0] not_finite
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [23:0] sample_out
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [skl_pkg::CeilBits-1:0]   ceil_r;
  logic [skl_pkg::KneeBits-1:0]   knee_r;
  logic [skl_pkg::BlkBits-1:0]    blk_r;
  logic                           out_valid_r;
  logic [skl_pkg::SampleBits-1:0] out_data_r;
  logic                           wr;
  logic [1:0]                     reg_idx;
  logic [skl_pkg::CeilBits-1:0]   ceil_wv;
  logic                           ceil_we;
  logic                           out_free;
  logic [skl_pkg::SampleBits-1:0] result;
  skl_pkg::dp_cmd_t               cmd;
  skl_pkg::dp_stat_t              stat;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];
  assign ceil_we    = wr && (reg_idx == skl_pkg::RegCeiling);

  always_comb begin
    ceil_wv = cfg_pwdata[skl_pkg::CeilBits-1:0];
    if (ceil_wv == '0) ceil_wv = skl_pkg::CeilBits'(1);
    else if (ceil_wv > skl_pkg::FullScale) ceil_wv = skl_pkg::FullScale;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r <= skl_pkg::FullScale;
      knee_r <= skl_pkg::KneeReset;
      blk_r  <= skl_pkg::BlkReset;
    end else if (wr) begin
      case (reg_idx)
        skl_pkg::RegCeiling: ceil_r <= ceil_wv;
        skl_pkg::RegKnee:    knee_r <= cfg_pwdata[skl_pkg::KneeBits-1:0];
        skl_pkg::RegBlock:   blk_r  <= cfg_pwdata[skl_pkg::BlkBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      skl_pkg::RegCeiling: cfg_prdata = 32'(ceil_r);
      skl_pkg::RegKnee:    cfg_prdata = 32'(knee_r);
      skl_pkg::RegBlock:   cfg_prdata = 32'(blk_r);
      default:             cfg_prdata = '0;
    endcase
  end

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  skl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  skl_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .sample_in     (in_tdata),
    .not_finite    (in_tuser[0]),
    .ceil_we       (ceil_we),
    .ceil_wdata    (ceil_wv),
    .ceiling       (ceil_r),
    .knee_fraction (knee_r),
    .block_length  (blk_r),
    .result        (result)
  );

endmodule
